// ===== hw/rtl/utrb_pkg.sv =====
`default_nettype none

package utrb_pkg;

  localparam logic [2:0] ACT_PUT   = 3'd0;
  localparam logic [2:0] ACT_GET   = 3'd1;
  localparam logic [2:0] ACT_READY = 3'd2;
  localparam logic [2:0] ACT_RECV  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       accepted;
    logic       echo_lost;
    logic [6:0] tx_level;
    logic [5:0] rx_level;
    logic       cr_seen;
    logic       lf_seen;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ECHO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic echo;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utrb_ctrl.sv =====
`default_nettype none

module utrb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  utrb_pkg::ctrl_sts_t  sts,
  output utrb_pkg::ctrl_cmd_t  cmd
);
  import utrb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_ECHO;
      ST_ECHO: state_next = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        item_ready  = 1'b1;
        cmd.capture = item_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_ECHO: cmd.echo = 1'b1;
      ST_OUT:  cmd.load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utrb_dp.sv =====
`default_nettype none

module utrb_dp #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  utrb_pkg::item_t      item,
  input  wire                  cfg_valid,
  input  wire                  cfg_data,
  input  utrb_pkg::ctrl_cmd_t  cmd,
  output utrb_pkg::ctrl_sts_t  sts,
  output logic                 result_valid,
  input  wire                  result_ready,
  output utrb_pkg::result_t    result
);
  import utrb_pkg::*;

  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_rdata;
  logic [7:0] rx_rdata;

  logic [TX_AW-1:0] tx_wr;
  logic [TX_AW-1:0] tx_rd;
  logic [TX_CW-1:0] tx_count;
  logic [RX_AW-1:0] rx_wr;
  logic [RX_AW-1:0] rx_rd;
  logic [RX_CW-1:0] rx_count;
  logic             cr_flag;
  logic             lf_flag;
  logic             echo_enable;

  item_t      cur;
  logic       hit;
  logic       from_rx;
  logic       acc;
  logic       echo_req;
  logic       lost;
  logic [7:0] obyte;

  logic       tx_full;
  logic       tx_push;
  logic       tx_pop;
  logic       rx_push;
  logic       rx_pop;
  logic       echo_push;
  logic [7:0] tx_wdata;
  logic [31:0] tx_level_wide;
  logic [31:0] rx_level_wide;

  assign tx_full = (tx_count == TX_CW'(TX_DEPTH));

  always_comb begin
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    echo_push = cmd.echo && echo_req && !tx_full;
    tx_wdata  = cur.data_byte;
    if (cmd.exec) begin
      case (cur.action)
        ACT_PUT:   tx_push = !tx_full;
        ACT_GET:   rx_pop  = (rx_count != '0);
        ACT_READY: tx_pop  = (tx_count != '0);
        ACT_RECV:  rx_push = (rx_count != RX_CW'(RX_DEPTH - 1));
        default:   tx_push = 1'b0;
      endcase
    end
    if (echo_push) begin
      tx_push  = 1'b1;
      tx_wdata = rx_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (tx_push) tx_mem[tx_wr] <= tx_wdata;
    tx_rdata <= tx_mem[tx_rd];
  end

  always_ff @(posedge clk) begin
    if (rx_push) rx_mem[rx_wr] <= cur.data_byte;
    rx_rdata <= rx_mem[rx_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wr       <= '0;
      tx_rd       <= '0;
      tx_count    <= '0;
      rx_wr       <= '0;
      rx_rd       <= '0;
      rx_count    <= '0;
      cr_flag     <= 1'b0;
      lf_flag     <= 1'b0;
      echo_enable <= 1'b0;
    end else begin
      if (cfg_valid) echo_enable <= cfg_data;
      if (tx_push) tx_wr <= (tx_wr == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr + 1'b1;
      if (tx_pop)  tx_rd <= (tx_rd == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd + 1'b1;
      if (tx_push && !tx_pop) tx_count <= tx_count + 1'b1;
      if (tx_pop && !tx_push) tx_count <= tx_count - 1'b1;
      if (rx_push) begin
        rx_wr    <= (rx_wr == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr + 1'b1;
        rx_count <= rx_count + 1'b1;
      end
      if (rx_pop) begin
        rx_rd    <= (rx_rd == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd + 1'b1;
        rx_count <= rx_count - 1'b1;
      end
      if (cmd.exec && cur.action == ACT_RECV) begin
        if (cur.data_byte == CHAR_CR) cr_flag <= 1'b1;
        if (cur.data_byte == CHAR_LF) lf_flag <= 1'b1;
      end
      if (cmd.exec && cur.action == ACT_CLEAR) begin
        cr_flag <= 1'b0;
        lf_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) cur <= item;
    if (cmd.exec) begin
      hit      <= rx_pop || tx_pop;
      from_rx  <= rx_pop;
      acc      <= tx_push || rx_push;
      echo_req <= rx_pop && echo_enable;
      lost     <= 1'b0;
    end
    if (cmd.echo) begin
      obyte <= hit ? (from_rx ? rx_rdata : tx_rdata) : 8'h00;
      lost  <= echo_req && tx_full;
    end
  end

  assign sts.out_free = !result_valid || result_ready;

  assign tx_level_wide = 32'(tx_count);
  assign rx_level_wide = 32'(rx_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.out_byte  <= obyte;
      result.out_valid <= hit;
      result.accepted  <= acc;
      result.echo_lost <= lost;
      result.tx_level  <= tx_level_wide[6:0];
      result.rx_level  <= rx_level_wide[5:0];
      result.cr_seen   <= cr_flag;
      result.lf_seen   <= lf_flag;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uart_tx_rx_ring_buffers.sv =====
`default_nettype none

// Channel   Handshake                Payload
// item      item_valid/item_ready    item (action, data_byte)
// result    result_valid/result_ready result (one per item)
// cfg       cfg_valid/cfg_ready      cfg_data (echo_enable)
//
// Each item steps through accept, execute (ring update, memory read issued),
// echo (read data captured, echo written into the transmit ring), load result.
// The result register frees the input side while a result waits to transfer.
// A stalled result holds the controller in its load step; no new item is taken.
// Synchronous reset empties both rings and clears flags and echo_enable.

module uart_tx_rx_ring_buffers #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_ready,
  input  utrb_pkg::item_t    item,
  output logic               result_valid,
  input  wire                result_ready,
  output utrb_pkg::result_t  result,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_data
);
  import utrb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  utrb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  utrb_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.exec, cmd.echo, cmd.load}))
    else $error("more than one datapath command active");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> cmd.exec)
    else $error("accepted item not executed next cycle");

  a_exec_echo: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> cmd.echo)
    else $error("echo step missing after execute");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!result_valid || result_ready))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire
